// ===== hw/rtl/dsv_pkg.sv =====
// dsv_pkg: types and constants shared by the date string validator.
// Channel item layouts, the parsed field set and calendar constants.
// No dependencies.
package dsv_pkg;

   // widths of the parsed fields
   localparam int DM_ACC_W    = 7;
   localparam int YEAR_ACC_W  = 14;
   localparam int DM_CNT_W    = 2;
   localparam int YEAR_CNT_W  = 3;
   localparam int MONTH_LEN_W = 5;

   // characters
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // digit count limits per field
   localparam logic [DM_CNT_W-1:0]   DM_MIN_DIGITS   = 2'd1;
   localparam logic [DM_CNT_W-1:0]   DM_MAX_DIGITS   = 2'd2;
   localparam logic [YEAR_CNT_W-1:0] YEAR_MIN_DIGITS = 3'd2;
   localparam logic [YEAR_CNT_W-1:0] YEAR_MAX_DIGITS = 3'd4;
   localparam logic [YEAR_CNT_W-1:0] YEAR_SHORT_DIGITS = 3'd2;

   localparam logic [YEAR_ACC_W-1:0] YEAR_BASE = 14'd2000;

   // months
   localparam logic [DM_ACC_W-1:0] MONTH_FIRST = 7'd1;
   localparam logic [DM_ACC_W-1:0] MONTH_LAST  = 7'd12;
   localparam logic [DM_ACC_W-1:0] MONTH_FEB   = 7'd2;
   localparam logic [DM_ACC_W-1:0] MONTH_APR   = 7'd4;
   localparam logic [DM_ACC_W-1:0] MONTH_JUN   = 7'd6;
   localparam logic [DM_ACC_W-1:0] MONTH_SEP   = 7'd9;
   localparam logic [DM_ACC_W-1:0] MONTH_NOV   = 7'd11;
   localparam logic [DM_ACC_W-1:0] DAY_FIRST   = 7'd1;

   localparam logic [MONTH_LEN_W-1:0] DAYS_FEB      = 5'd28;
   localparam logic [MONTH_LEN_W-1:0] DAYS_FEB_LEAP = 5'd29;
   localparam logic [MONTH_LEN_W-1:0] DAYS_SHORT    = 5'd30;
   localparam logic [MONTH_LEN_W-1:0] DAYS_LONG     = 5'd31;

   // year / 100 by reciprocal: (y * 5243) >> 19, exact for every 14-bit year up to 9999
   localparam int RECIP_SHIFT = 19;
   localparam int CENT_W      = 8;
   localparam int PROD_W      = RECIP_SHIFT + CENT_W;
   localparam logic [PROD_W-1:0]     RECIP_100 = 27'd5243;
   localparam logic [YEAR_ACC_W-1:0] CENTURY   = 14'd100;

   typedef struct packed {
      logic [7:0] text_char;
      logic       is_last;
   } req_item_type;

   typedef struct packed {
      logic                  date_valid;
      logic [DM_ACC_W-1:0]   day_value;
      logic [DM_ACC_W-1:0]   month_value;
      logic [YEAR_ACC_W-1:0] year_value;
   } rsp_item_type;

   // digit counts and decimal values of the three fields
   typedef struct packed {
      logic [DM_CNT_W-1:0]   day_digits;
      logic [DM_CNT_W-1:0]   month_digits;
      logic [YEAR_CNT_W-1:0] year_digits;
      logic [DM_ACC_W-1:0]   day_acc;
      logic [DM_ACC_W-1:0]   month_acc;
      logic [YEAR_ACC_W-1:0] year_acc;
   } field_set_type;

endpackage

// ===== hw/rtl/dsv_req_if.sv =====
// dsv_req_if: valid/ready channel carrying one character item.
// Depends on dsv_pkg for the item layout.
interface dsv_req_if;
   logic                  valid;
   logic                  ready;
   dsv_pkg::req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

// ===== hw/rtl/dsv_rsp_if.sv =====
// dsv_rsp_if: valid/ready channel carrying one parsed date item.
// Depends on dsv_pkg for the item layout.
interface dsv_rsp_if;
   logic                  valid;
   logic                  ready;
   dsv_pkg::rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

// ===== hw/rtl/dsv_field_parser.sv =====
// dsv_field_parser: input register, field phase and decimal accumulators.
// Hands the finished field set of each string to the checker.
// Depends on dsv_pkg and dsv_req_if.
module dsv_field_parser (
   input  logic                   clock,
   input  logic                   reset,
   dsv_req_if.sink                req_chan,
   output logic                   fields_valid,
   output dsv_pkg::field_set_type fields,
   input  logic                   fields_ready
);
   import dsv_pkg::*;

   localparam logic [1:0] PHASE_DAY   = 2'd0;
   localparam logic [1:0] PHASE_MONTH = 2'd1;
   localparam logic [1:0] PHASE_YEAR  = 2'd2;

   logic          in_valid_ff, in_valid_in;
   req_item_type  in_item_ff;
   logic [1:0]    phase_ff, phase_in, phase_next;
   field_set_type acc_ff, acc_in, work;
   logic          fld_valid_ff, fld_valid_in;
   field_set_type fld_ff, fld_in;

   logic          consume;
   logic          is_digit;
   logic [3:0]    digit_val;
   logic [7:0]    char_off;

   // a last item needs room in the field register, others just update state
   assign consume        = in_valid_ff && (!in_item_ff.is_last || !fld_valid_ff || fields_ready);
   assign req_chan.ready = !in_valid_ff || consume;

   assign char_off  = in_item_ff.text_char - CHAR_ZERO;
   assign digit_val = char_off[3:0];

   always_comb begin
      is_digit   = in_item_ff.text_char inside {[CHAR_ZERO:CHAR_NINE]};
      work       = acc_ff;
      phase_next = phase_ff;
      case (phase_ff)
         PHASE_DAY: begin
            if (is_digit) begin
               if (work.day_digits < DM_MAX_DIGITS)
                  work.day_acc = DM_ACC_W'(work.day_acc * 7'd10 + DM_ACC_W'(digit_val));
               if (work.day_digits <= DM_MAX_DIGITS)
                  work.day_digits = DM_CNT_W'(work.day_digits + 2'd1);
            end else if (in_item_ff.text_char == CHAR_SLASH) begin
               phase_next = PHASE_MONTH;
            end
         end
         PHASE_MONTH: begin
            if (is_digit) begin
               if (work.month_digits < DM_MAX_DIGITS)
                  work.month_acc = DM_ACC_W'(work.month_acc * 7'd10 + DM_ACC_W'(digit_val));
               if (work.month_digits <= DM_MAX_DIGITS)
                  work.month_digits = DM_CNT_W'(work.month_digits + 2'd1);
            end else if (in_item_ff.text_char == CHAR_SLASH) begin
               phase_next = PHASE_YEAR;
            end
         end
         default: begin
            // year field: further slashes are ignored
            if (is_digit) begin
               if (work.year_digits < YEAR_MAX_DIGITS)
                  work.year_acc =
                     YEAR_ACC_W'(work.year_acc * 14'd10 + YEAR_ACC_W'(digit_val));
               if (work.year_digits <= YEAR_MAX_DIGITS)
                  work.year_digits = YEAR_CNT_W'(work.year_digits + 3'd1);
            end
         end
      endcase
   end

   always_comb begin
      in_valid_in  = req_chan.ready ? req_chan.valid : 1'b1;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      fld_in       = fld_ff;
      fld_valid_in = fld_valid_ff && !fields_ready;
      if (consume) begin
         if (in_item_ff.is_last) begin
            phase_in     = PHASE_DAY;
            acc_in       = '0;
            fld_in       = work;
            fld_valid_in = 1'b1;
         end else begin
            phase_in = phase_next;
            acc_in   = work;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= PHASE_DAY;
         acc_ff       <= '0;
         fld_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         fld_valid_ff <= fld_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff <= req_chan.item;
      end
      fld_ff <= fld_in;
   end

   assign fields_valid = fld_valid_ff;
   assign fields       = fld_ff;

endmodule

// ===== hw/rtl/dsv_date_check.sv =====
// dsv_date_check: calendar check of a parsed field set and the result register.
// Applies the two-digit year offset and the Gregorian leap rule.
// Depends on dsv_pkg and dsv_rsp_if.
module dsv_date_check (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fields_valid,
   input  dsv_pkg::field_set_type fields,
   output logic                   fields_ready,
   dsv_rsp_if.source              rsp_chan
);
   import dsv_pkg::*;

   logic                   out_valid_ff, out_valid_in;
   rsp_item_type           out_item_ff, out_item_in;

   logic [PROD_W-1:0]      prod;
   logic [CENT_W-1:0]      cent;
   logic                   is_century;
   logic                   is_leap;
   logic [MONTH_LEN_W-1:0] month_len;
   logic [YEAR_ACC_W-1:0]  year_out;
   logic                   counts_ok;
   logic                   date_ok;

   assign fields_ready = !out_valid_ff || rsp_chan.ready;

   // adding 2000 never changes the leap answer, so test the raw value
   assign prod       = PROD_W'(fields.year_acc) * RECIP_100;
   assign cent       = prod[RECIP_SHIFT +: CENT_W];
   assign is_century = (YEAR_ACC_W'(cent) * CENTURY) == fields.year_acc;
   assign is_leap    = (fields.year_acc[1:0] == 2'b00) && (!is_century || cent[1:0] == 2'b00);

   assign year_out = (fields.year_digits == YEAR_SHORT_DIGITS)
                     ? YEAR_ACC_W'(fields.year_acc + YEAR_BASE) : fields.year_acc;

   always_comb begin
      case (fields.month_acc)
         MONTH_FEB: month_len = is_leap ? DAYS_FEB_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_len = DAYS_SHORT;
         default: month_len = DAYS_LONG;
      endcase
   end

   always_comb begin
      counts_ok = (fields.day_digits inside {[DM_MIN_DIGITS:DM_MAX_DIGITS]})
               && (fields.month_digits inside {[DM_MIN_DIGITS:DM_MAX_DIGITS]})
               && (fields.year_digits inside {[YEAR_MIN_DIGITS:YEAR_MAX_DIGITS]});
      date_ok   = (fields.month_acc inside {[MONTH_FIRST:MONTH_LAST]})
               && (fields.day_acc >= DAY_FIRST)
               && (fields.day_acc <= DM_ACC_W'(month_len));
      out_item_in.date_valid  = counts_ok && date_ok;
      out_item_in.day_value   = fields.day_acc;
      out_item_in.month_value = fields.month_acc;
      out_item_in.year_value  = year_out;
   end

   assign out_valid_in = (fields_valid && fields_ready) || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fields_valid && fields_ready) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.item  = out_item_ff;

endmodule

// ===== hw/rtl/date_string_validator_unit.sv =====
// date_string_validator_unit: top level of the d/m/y date string validator.
// Depends on dsv_pkg, dsv_req_if, dsv_rsp_if, dsv_field_parser and dsv_date_check.
//
// Usage:
//   req_chan takes one character item per handshake, text_char plus is_last
//   on the final character of a string. Digits build the day, month and
//   year fields, the first two slashes step to the next field, anything else
//   is skipped.
//   rsp_chan gives one item per string, after its last character: date_valid
//   and the parsed day, month and year (two-digit years plus 2000).
//   Throughput: one character per cycle, except while req_chan.ready is low
//   (see Stall). The result passes through the input register, the field
//   register and the result register, in that order.
//   Reset: synchronous; clears the field phase and accumulators and empties
//   all three registers, so the first character after reset starts a string.
//   Stall: while a result waits on rsp_chan, characters keep flowing into the
//   accumulators; the field register holds one more finished string, and
//   req_chan.ready drops only when a further last character finds both full.
module date_string_validator_unit (
   input logic       clock,
   input logic       reset,
   dsv_req_if.sink   req_chan,
   dsv_rsp_if.source rsp_chan
);
   import dsv_pkg::*;

   logic          fields_valid;
   logic          fields_ready;
   field_set_type fields;

   dsv_field_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .fields_valid (fields_valid),
      .fields       (fields),
      .fields_ready (fields_ready)
   );

   dsv_date_check u_check (
      .clock        (clock),
      .reset        (reset),
      .fields_valid (fields_valid),
      .fields       (fields),
      .fields_ready (fields_ready),
      .rsp_chan     (rsp_chan)
   );

   // a stalled field set stays put until the checker takes it
   a_fields_hold: assert property (@(posedge clock) disable iff (reset)
      fields_valid && !fields_ready |=> fields_valid && $stable(fields))
      else $error("field set changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

   // a new result only comes from a field set handed over the cycle before
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(fields_valid && fields_ready))
      else $error("result appeared without a field set");

   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.item.date_valid |->
         rsp_chan.item.month_value >= MONTH_FIRST && rsp_chan.item.month_value <= MONTH_LAST
         && rsp_chan.item.day_value >= DAY_FIRST
         && rsp_chan.item.day_value <= DM_ACC_W'(DAYS_LONG))
      else $error("valid date out of calendar range");

endmodule

// ===== tb/tb_date_string_validator_unit.sv =====
`timescale 1ns / 100ps
// tb_date_string_validator_unit: self-checking bench for the d/m/y date string validator.
// Drives character items on dsv_req_if, checks parsed dates on dsv_rsp_if against a local
// parser model. Depends on dsv_pkg, dsv_req_if, dsv_rsp_if and date_string_validator_unit.
module tb_date_string_validator_unit;
   import dsv_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 3;
   localparam int RANDOM_ITEMS = 1750;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   typedef enum logic [1:0] {FIELD_DAY, FIELD_MONTH, FIELD_YEAR} parse_phase_type;

   typedef struct {
      string text;
      bit    typed;
      bit    valid;
      int    day;
      int    month;
      int    year;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dsv_req_if req_chan();
   dsv_rsp_if rsp_chan();

   date_string_validator_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLOCK_HALF) clock = ~clock;

   parse_phase_type parse_field;
   field_set_type   fields;
   rsp_item_type    expected_dates[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              send_idle_pct;
   int              rsp_idle_pct;

   function automatic logic [MONTH_LEN_W-1:0] days_in_month(
      input logic [DM_ACC_W-1:0] month, input logic [YEAR_ACC_W-1:0] year);
      logic leap;
      leap = (year % 400 == 0) || ((year % 100 != 0) && (year % 4 == 0));
      if (month == MONTH_FEB) return leap ? DAYS_FEB_LEAP : DAYS_FEB;
      if (month == MONTH_APR || month == MONTH_JUN || month == MONTH_SEP || month == MONTH_NOV)
         return DAYS_SHORT;
      return DAYS_LONG;
   endfunction

   // advances the parser by one character, returns 1 when a date item is produced
   function automatic bit parse_char(input logic [7:0] c, input logic last,
                                     output rsp_item_type date);
      logic                  digit;
      logic [3:0]            d;
      logic [YEAR_ACC_W-1:0] year;
      logic                  ok;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d = 4'(c - CHAR_ZERO);
      date = '0;
      case (parse_field)
         FIELD_DAY: begin
            if (digit) begin
               if (fields.day_digits < DM_MAX_DIGITS)
                  fields.day_acc = DM_ACC_W'(fields.day_acc * 10 + d);
               if (fields.day_digits <= DM_MAX_DIGITS) fields.day_digits++;
            end else if (c == CHAR_SLASH) begin
               parse_field = FIELD_MONTH;
            end
         end
         FIELD_MONTH: begin
            if (digit) begin
               if (fields.month_digits < DM_MAX_DIGITS)
                  fields.month_acc = DM_ACC_W'(fields.month_acc * 10 + d);
               if (fields.month_digits <= DM_MAX_DIGITS) fields.month_digits++;
            end else if (c == CHAR_SLASH) begin
               parse_field = FIELD_YEAR;
            end
         end
         default: begin
            // slashes are plain junk once in the year
            if (digit) begin
               if (fields.year_digits < YEAR_MAX_DIGITS)
                  fields.year_acc = YEAR_ACC_W'(fields.year_acc * 10 + d);
               if (fields.year_digits <= YEAR_MAX_DIGITS) fields.year_digits++;
            end
         end
      endcase
      if (!last) return 1'b0;
      year = fields.year_acc;
      if (fields.year_digits == YEAR_SHORT_DIGITS) year = YEAR_ACC_W'(year + YEAR_BASE);
      ok = (fields.day_digits >= DM_MIN_DIGITS) && (fields.day_digits <= DM_MAX_DIGITS)
         && (fields.month_digits >= DM_MIN_DIGITS) && (fields.month_digits <= DM_MAX_DIGITS)
         && (fields.year_digits >= YEAR_MIN_DIGITS) && (fields.year_digits <= YEAR_MAX_DIGITS)
         && (fields.month_acc >= MONTH_FIRST) && (fields.month_acc <= MONTH_LAST)
         && (fields.day_acc >= DAY_FIRST)
         && (fields.day_acc <= days_in_month(fields.month_acc, year));
      date.date_valid  = ok;
      date.day_value   = fields.day_acc;
      date.month_value = fields.month_acc;
      date.year_value  = year;
      parse_field = FIELD_DAY;
      fields = '0;
      return 1'b1;
   endfunction

   function automatic void append_number(ref logic [7:0] chars[$], input int unsigned value,
                                         input int unsigned ndig);
      int unsigned scale;
      scale = 1;
      repeat (ndig) scale *= 10;
      repeat (ndig) begin
         scale /= 10;
         chars.push_back(CHAR_ZERO + 8'((value / scale) % 10));
      end
   endfunction

   // any byte that is neither a digit nor a slash
   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CHAR_SLASH || (c >= CHAR_ZERO && c <= CHAR_NINE));
      return c;
   endfunction

   // digits to print a day or month with: sometimes padded, now and then too many
   function automatic int unsigned field_width(input int unsigned value);
      if ($urandom_range(0, 19) == 0) return 3;
      return (value >= 10 || $urandom_range(0, 1) == 1) ? 2 : 1;
   endfunction

   function automatic void append_separator(ref logic [7:0] chars[$]);
      int unsigned pick;
      pick = $urandom_range(0, 29);
      if (pick == 0) return;
      if (pick < 4) chars.push_back(junk_char());
      chars.push_back(CHAR_SLASH);
      if (pick == 4) chars.push_back(CHAR_SLASH);
   endfunction

   task automatic build_random_date(ref logic [7:0] chars[$]);
      int unsigned kind, n, month, day, year, eff_year, ydig, len, pick;
      chars.delete();
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         n = $urandom_range(1, 8);
         repeat (n) chars.push_back(8'($urandom_range(0, 255)));
      end else if (kind <= 3) begin
         // digit and slash soup
         n = $urandom_range(1, 14);
         repeat (n)
            chars.push_back(($urandom_range(0, 3) == 0) ? CHAR_SLASH
                                                         : CHAR_ZERO + 8'($urandom_range(0, 9)));
      end else begin
         pick = $urandom_range(0, 19);
         ydig = (pick < 13) ? 4 : (pick < 17) ? 2 : (pick == 17) ? 3 : (pick == 18) ? 5
              : $urandom_range(0, 1);
         case (ydig)
            4: year = ($urandom_range(0, 3) == 0) ? 100 * $urandom_range(0, 99)
                                                   : $urandom_range(0, 9999);
            3: year = $urandom_range(0, 999);
            2: year = $urandom_range(0, 99);
            5: year = $urandom_range(0, 99999);
            1: year = $urandom_range(0, 9);
            default: year = 0;
         endcase
         eff_year = (ydig == 2) ? year + 2000 : (ydig == 5) ? year / 10 : year;
         month = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
         len = (month >= 1 && month <= 12)
             ? days_in_month(DM_ACC_W'(month), YEAR_ACC_W'(eff_year)) : 31;
         // lean on month ends so leap and short months get hit
         pick = $urandom_range(0, 9);
         if (pick < 4) day = len - 1 + $urandom_range(0, 2);
         else if (pick == 4) day = $urandom_range(0, 99);
         else day = $urandom_range(1, len);
         if ($urandom_range(0, 7) == 0) chars.push_back(junk_char());
         append_number(chars, day, field_width(day));
         append_separator(chars);
         append_number(chars, month, field_width(month));
         append_separator(chars);
         append_number(chars, year, ydig);
         if ($urandom_range(0, 7) == 0) chars.push_back(junk_char());
         if (chars.size() == 0) chars.push_back(junk_char());
      end
   endtask

   task automatic send_char(input logic [7:0] c, input logic last, input bit typed,
                            input rsp_item_type typed_date);
      rsp_item_type date;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.item.text_char <= c;
      req_chan.item.is_last   <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (parse_char(c, last, date)) expected_dates.push_back(typed ? typed_date : date);
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock);
      while (expected_dates.size() != 0);
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_item_type want;
      rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_dates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected date item: valid=%0d day=%0d month=%0d year=%0d",
                        rsp_chan.item.date_valid, rsp_chan.item.day_value,
                        rsp_chan.item.month_value, rsp_chan.item.year_value);
         end else begin
            want = expected_dates.pop_front();
            if (rsp_chan.item.date_valid !== want.date_valid
                || rsp_chan.item.day_value !== want.day_value
                || rsp_chan.item.month_value !== want.month_value
                || rsp_chan.item.year_value !== want.year_value) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("date mismatch: expected valid=%0d day=%0d month=%0d year=%0d, %s",
                           want.date_valid, want.day_value, want.month_value,
                           want.year_value,
                           $sformatf("got valid=%0d day=%0d month=%0d year=%0d",
                                     rsp_chan.item.date_valid, rsp_chan.item.day_value,
                                     rsp_chan.item.month_value, rsp_chan.item.year_value));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_date_string_validator_unit: errors");
         $finish;
      end
   end

   initial begin
      logic [7:0]   chars[$];
      int           items_sent;
      dir_row_type  dir_rows[5];
      rsp_item_type want;
      req_chan.valid = 1'b0;
      req_chan.item  = '0;
      rsp_chan.ready = 1'b0;
      parse_field    = FIELD_DAY;
      fields         = '0;
      send_idle_pct  = 18;
      rsp_idle_pct   = 82;

      // lone top byte: every field empty
      dir_rows[0] = '{"\377", 1'b1, 1'b0, 0, 0, 0};
      // smallest date, two-digit year
      dir_rows[1] = '{"1/1/00", 1'b1, 1'b1, 1, 1, 2000};
      // century that is not a leap year
      dir_rows[2] = '{"29/2/1900", 1'b0, 1'b0, 0, 0, 0};
      // day too long, month and year empty
      dir_rows[3] = '{"123//", 1'b1, 1'b0, 12, 0, 0};
      // largest values, slash in the year ignored, year too long
      dir_rows[4] = '{"31/12/9999/9", 1'b1, 1'b0, 31, 12, 9999};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         want.date_valid  = dir_rows[r].valid;
         want.day_value   = DM_ACC_W'(dir_rows[r].day);
         want.month_value = DM_ACC_W'(dir_rows[r].month);
         want.year_value  = YEAR_ACC_W'(dir_rows[r].year);
         for (int i = 0; i < dir_rows[r].text.len(); i++)
            send_char(dir_rows[r].text[i], i == dir_rows[r].text.len() - 1,
                      dir_rows[r].typed, want);
      end

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (send_idle_pct == 18 && items_sent >= RANDOM_ITEMS / 3) begin
            wait_for_drain();
            send_idle_pct = 82;
            rsp_idle_pct  = 18;
         end else if (send_idle_pct == 82 && items_sent >= 2 * RANDOM_ITEMS / 3) begin
            wait_for_drain();
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         build_random_date(chars);
         foreach (chars[i]) send_char(chars[i], i == chars.size() - 1, 1'b0, '0);
         items_sent += chars.size();
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_date_string_validator_unit: clean");
      end else begin
         $display("tb_date_string_validator_unit: errors");
      end
      $finish;
   end

endmodule
